// ----- src/assert_macros.svh -----
// Assertion macros used by the fold datapath module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define EFRI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define EFRI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/efri_pkg.sv -----
// Package for the quartic extension fold: field constants, types, codes and helpers.
`timescale 1ns / 1ps

package efri_pkg;

   // Field and Montgomery constants (R = 2^32)
   localparam logic [30:0] PRIME      = 31'd2013265921;
   localparam logic [31:0] MONT_NINV  = 32'h77ffffff;
   localparam logic [30:0] MONT_ONE   = 31'd268435454;
   localparam logic [30:0] MONT_NEG11 = 31'd1073741848;

   localparam int FIELD_W  = 31;
   localparam int ELEM_W   = 4 * FIELD_W;
   localparam int TDATA_W  = ((ELEM_W + 7) / 8) * 8;
   localparam int FOLD_DEF = 16;

   // Configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_MIX_C0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIX_C1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIX_C2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIX_C3 = 2'd3;

   // Step of the extension multiply that folds the high half back by -11
   localparam logic [2:0] STEP_FOLD = 3'd4;

   // One extension element, component 0 in the low bits
   typedef logic [3:0][FIELD_W-1:0] elem_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD_INIT,
      ST_MUL,
      ST_BUILD_WR,
      ST_READ,
      ST_LOAD,
      ST_ACCUM
   } state_type;

   // Phases of one Montgomery product on the shared multiplier
   typedef enum logic [2:0] {
      PH_MUL,
      PH_QUO,
      PH_QP,
      PH_RED,
      PH_ACC
   } phase_type;

   // Modular add of two reduced values
   function automatic logic [FIELD_W-1:0] madd(input logic [FIELD_W-1:0] x,
                                               input logic [FIELD_W-1:0] y);
      logic [FIELD_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, PRIME}) begin
         s = s - {1'b0, PRIME};
      end
      return s[FIELD_W-1:0];
   endfunction

endpackage

// ----- src/extension_fri_fold.sv -----
// Top level of the FRI fold over the quartic extension of the 31-bit prime field.
// Each accepted element passes through a table read, a load, the extension multiply on
// the single shared Montgomery multiplier (20 products, each in five phases) and an
// accumulate step that, at the end of a group, also registers the group sum.
// The first element of a group after reset or a mix write first rebuilds the power
// table of 2^ceil(log2(FOLD)) entries. Synchronous active-high reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module extension_fri_fold
   import efri_pkg::*;
#(
   parameter int FOLD = FOLD_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // csr write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,  // value_c0, value_c1, value_c2, value_c3, zero pad
   // response stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata   // sum_c0, sum_c1, sum_c2, sum_c3, zero pad
);

   localparam int SLOT_W    = $clog2(FOLD);
   localparam int TBL_DEPTH = 1 << SLOT_W;

   // Control state
   state_type           state_ff, state_in;
   logic                stale_ff, stale_in;
   logic                building_ff, building_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Sequencer of the extension multiply
   logic [1:0]          n_ff, n_in;
   logic [2:0]          i_ff, i_in;
   phase_type           ph_ff, ph_in;

   // Datapath
   elem_type            mix_ff, mix_in;
   elem_type            a_ff, a_in;
   elem_type            b_ff, b_in;
   elem_type            r_ff, r_in;
   elem_type            val_ff, val_in;
   elem_type            acc_ff, acc_in;
   elem_type            rsp_data_ff, rsp_data_in;
   logic [FIELD_W-1:0]  low_ff, low_in;
   logic [FIELD_W-1:0]  high_ff, high_in;
   logic [61:0]         prod_ff, prod_in;
   logic [31:0]         q_ff, q_in;
   logic                carry_ff, carry_in;
   logic [62:0]         qp_ff, qp_in;
   logic [FIELD_W-1:0]  mres_ff, mres_in;

   // Power table
   elem_type            power_mem [TBL_DEPTH];
   elem_type            rd_ff;
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;
   elem_type            mem_wdata;
   logic [SLOT_W-1:0]   rd_addr;

   // Shared multiplier operands and helpers
   logic [1:0]          step_idx;
   logic [1:0]          b_idx;
   logic [FIELD_W-1:0]  mul_a;
   logic [FIELD_W-1:0]  mul_b;
   logic [31:0]         red_sum;
   logic                last_slot;
   logic                out_free;
   elem_type            sum_elem;
   elem_type            one_elem;
   logic                engine_rest;
   logic                mres_used;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - ELEM_W){1'b0}}, rsp_data_ff};

   assign one_elem  = {{(3 * FIELD_W){1'b0}}, MONT_ONE};
   assign last_slot = (slot_ff == SLOT_W'(FOLD - 1));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Pick operands: a[i] * b[n-i], or -11 times the high partial sum
   assign step_idx = i_ff[1:0];
   assign b_idx    = n_ff - step_idx;
   assign mul_a    = (i_ff == STEP_FOLD) ? MONT_NEG11 : a_ff[step_idx];
   assign mul_b    = (i_ff == STEP_FOLD) ? high_ff : b_ff[b_idx];

   // Table address: slot with its low bits reversed
   always_comb begin
      for (int k = 0; k < SLOT_W; k++) begin
         rd_addr[k] = slot_ff[SLOT_W - 1 - k];
      end
   end

   // Group sum with the finished product
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sum_elem[k] = madd(acc_ff[k], r_ff[k]);
      end
   end

   // Montgomery product steps. Since MONT_NINV * PRIME = -1 mod 2^32, the low word of
   // q * PRIME is the negated low word of the product, so the carry is "low word nonzero".
   assign prod_in  = 62'(mul_a) * 62'(mul_b);
   assign q_in     = prod_ff[31:0] * MONT_NINV;
   assign carry_in = |prod_ff[31:0];
   assign qp_in    = 63'(q_ff) * 63'(PRIME);
   assign red_sum  = 32'(prod_ff[61:32]) + 32'(qp_ff[62:32]) + 32'(carry_ff);
   assign mres_in  = (red_sum >= 32'(PRIME)) ? 31'(red_sum - 32'(PRIME)) : red_sum[30:0];

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      stale_in     = stale_ff;
      building_in  = building_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      ph_in        = ph_ff;
      mix_in       = mix_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      r_in         = r_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = r_ff;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes mark the table stale for the next group
      if (csr_we) begin
         case (csr_index)
            REG_MIX_C0: begin
               mix_in[0] = csr_wdata;
               stale_in  = 1'b1;
            end
            REG_MIX_C1: begin
               mix_in[1] = csr_wdata;
               stale_in  = 1'b1;
            end
            REG_MIX_C2: begin
               mix_in[2] = csr_wdata;
               stale_in  = 1'b1;
            end
            REG_MIX_C3: begin
               mix_in[3] = csr_wdata;
               stale_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               val_in = req_tdata[ELEM_W-1:0];
               if (stale_ff && (slot_ff == '0)) begin
                  state_in = ST_BUILD_INIT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end

         ST_BUILD_INIT: begin
            mem_we      = 1'b1;
            mem_waddr   = '0;
            mem_wdata   = one_elem;
            a_in        = one_elem;
            b_in        = mix_ff;
            idx_in      = SLOT_W'(1);
            building_in = 1'b1;
            stale_in    = 1'b0;
            state_in    = ST_MUL;
         end

         ST_MUL: begin
            case (ph_ff)
               PH_MUL: ph_in = PH_QUO;
               PH_QUO: ph_in = PH_QP;
               PH_QP:  ph_in = PH_RED;
               PH_RED: ph_in = PH_ACC;
               PH_ACC: begin
                  ph_in = PH_MUL;
                  if (i_ff == STEP_FOLD) begin
                     // Close one output component
                     r_in[n_ff] = madd(low_ff, mres_ff);
                     low_in     = '0;
                     high_in    = '0;
                     i_in       = '0;
                     n_in       = n_ff + 2'd1;
                     if (n_ff == 2'd3) begin
                        state_in = building_ff ? ST_BUILD_WR : ST_ACCUM;
                     end
                  end else begin
                     // Products that wrap past degree three go to the high sum
                     if (step_idx <= n_ff) begin
                        low_in = madd(low_ff, mres_ff);
                     end else begin
                        high_in = madd(high_ff, mres_ff);
                     end
                     i_in = i_ff + 3'd1;
                  end
               end
               default: ph_in = PH_MUL;
            endcase
         end

         ST_BUILD_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = r_ff;
            a_in      = r_ff;
            if (idx_ff == SLOT_W'(TBL_DEPTH - 1)) begin
               building_in = 1'b0;
               state_in    = ST_READ;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = ST_MUL;
            end
         end

         ST_READ: begin
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            a_in     = rd_ff;
            b_in     = val_ff;
            state_in = ST_MUL;
         end

         ST_ACCUM: begin
            if (!last_slot) begin
               acc_in   = sum_elem;
               slot_in  = slot_ff + SLOT_W'(1);
               state_in = ST_IDLE;
            end else if (out_free) begin
               // Emit the group sum and start a fresh group
               rsp_data_in  = sum_elem;
               rsp_valid_in = 1'b1;
               acc_in       = '0;
               slot_in      = '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stale_ff     <= 1'b1;
         building_ff  <= 1'b0;
         slot_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         i_ff         <= '0;
         ph_ff        <= PH_MUL;
         mix_ff       <= one_elem;
         acc_ff       <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         stale_ff     <= stale_in;
         building_ff  <= building_in;
         slot_ff      <= slot_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         ph_ff        <= ph_in;
         mix_ff       <= mix_in;
         acc_ff       <= acc_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      r_ff        <= r_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= prod_in;
      q_ff        <= q_in;
      carry_ff    <= carry_in;
      qp_ff       <= qp_in;
      mres_ff     <= mres_in;
   end

   // Power table memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         power_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= power_mem[rd_addr];
   end

   // Engine at rest, and a finished product about to be summed
   assign engine_rest = (ph_ff == PH_MUL) && (i_ff == 3'd0) && (n_ff == 2'd0) &&
                        (low_ff == '0) && (high_ff == '0);
   assign mres_used   = (state_ff == ST_MUL) && (ph_ff == PH_ACC);

   `EFRI_ASSERT(a_idle_engine, req_tready |-> engine_rest, "engine not at rest while accepting")
   `EFRI_ASSERT(a_mres_reduced, mres_used |-> (mres_ff < PRIME), "product not reduced")
   `EFRI_ASSERT(a_step_range, i_ff <= STEP_FOLD, "multiply step out of range")
   `EFRI_ASSERT(a_slot_range, slot_ff <= SLOT_W'(FOLD - 1), "slot counter past group end")
   `EFRI_ASSERT(a_emit_group_end, $rose(rsp_tvalid) |-> (slot_ff == '0), "sum emitted mid-group")

endmodule

// ----- dv/tb_extension_fri_fold.sv -----
// Self-checking testbench for the quartic extension FRI fold with a built-in folded-sum model.
`timescale 1ns / 1ps

module tb_extension_fri_fold;
   import efri_pkg::*;

   localparam int SLOT_BITS    = $clog2(FOLD_DEF);
   localparam int POWER_DEPTH  = 64;
   localparam int DRAIN_CYCLES = 2000;     // covers a table rebuild plus one element
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 97;
   localparam int PHASE_COUNT  = 8;
   localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_PERIODIC,
      READY_SPARSE
   } stall_type;

   // Folded-sum predictor: mirrors the power table, the accumulator and the slot
   class fold_scoreboard;
      elem_type    mix;
      elem_type    powers [POWER_DEPTH];
      elem_type    acc;
      int unsigned slot;
      elem_type    pending_sums [$];
      int          errors;
      int          sums_checked;
      int          elements_taken;

      function new();
         mix = '0;
         mix[0] = MONT_ONE;
         acc = '0;
         slot = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
         end
      endfunction

      // Montgomery product with R = 2^32; inputs may be unreduced 31-bit values
      function logic [FIELD_W-1:0] mont_mul(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
         logic [63:0] prod;
         logic [31:0] q;
         logic [63:0] total;
         logic [31:0] res;
         prod  = 64'(a) * 64'(b);
         q     = prod[31:0] * MONT_NINV;
         total = prod + 64'(q) * 64'(PRIME);
         res   = total[63:32];
         if (res >= 32'(PRIME)) begin
            res = res - 32'(PRIME);
         end
         return res[FIELD_W-1:0];
      endfunction

      function logic [FIELD_W-1:0] fp_add(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
         logic [31:0] s;
         s = 32'(a) + 32'(b);
         if (s >= 32'(PRIME)) begin
            s = s - 32'(PRIME);
         end
         return s[FIELD_W-1:0];
      endfunction

      // Product in F_p[x]/(x^4 + 11): high terms fold back with -11
      function elem_type ext_mul(elem_type a, elem_type b);
         elem_type r;
         r[0] = fp_add(mont_mul(a[0], b[0]),
                       mont_mul(MONT_NEG11,
                                fp_add(fp_add(mont_mul(a[1], b[3]), mont_mul(a[2], b[2])),
                                       mont_mul(a[3], b[1]))));
         r[1] = fp_add(fp_add(mont_mul(a[0], b[1]), mont_mul(a[1], b[0])),
                       mont_mul(MONT_NEG11,
                                fp_add(mont_mul(a[2], b[3]), mont_mul(a[3], b[2]))));
         r[2] = fp_add(fp_add(fp_add(mont_mul(a[0], b[2]), mont_mul(a[1], b[1])),
                              mont_mul(a[2], b[0])),
                       mont_mul(MONT_NEG11, mont_mul(a[3], b[3])));
         r[3] = fp_add(fp_add(fp_add(mont_mul(a[0], b[3]), mont_mul(a[1], b[2])),
                              mont_mul(a[2], b[1])),
                       mont_mul(a[3], b[0]));
         return r;
      endfunction

      function void note_mix(logic [CSR_IDX_W-1:0] idx, logic [FIELD_W-1:0] value);
         case (idx)
            REG_MIX_C0: mix[0] = value;
            REG_MIX_C1: mix[1] = value;
            REG_MIX_C2: mix[2] = value;
            REG_MIX_C3: mix[3] = value;
            default: ;
         endcase
      endfunction

      // Advance the fold by one accepted element; queue the sum at the end of a group
      function void take_element(elem_type value);
         elem_type    prod;
         int unsigned rev;
         elements_taken++;
         if (slot == 0) begin
            powers[0] = '0;
            powers[0][0] = MONT_ONE;
            for (int i = 1; i < POWER_DEPTH; i++) begin
               powers[i] = ext_mul(powers[i-1], mix);
            end
         end
         rev = 0;
         for (int b = 0; b < SLOT_BITS; b++) begin
            rev = (rev << 1) | ((slot >> b) & 1);
         end
         prod = ext_mul(powers[rev % POWER_DEPTH], value);
         for (int k = 0; k < 4; k++) begin
            acc[k] = fp_add(acc[k], prod[k]);
         end
         slot++;
         if (slot >= FOLD_DEF) begin
            pending_sums.push_back(acc);
            acc = '0;
            slot = 0;
         end
      endfunction

      // Compare one returned sum with the oldest expected sum
      function void check_sum(elem_type got);
         elem_type want;
         if (pending_sums.size() == 0) begin
            flag($sformatf("unexpected sum %h", got));
            return;
         end
         want = pending_sums.pop_front();
         for (int k = 0; k < 4; k++) begin
            if (got[k] !== want[k]) begin
               flag($sformatf("sum %0d sum_c%0d: expected %0d, got %0d",
                              sums_checked, k, want[k], got[k]));
            end
         end
         sums_checked++;
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIELD_W-1:0]   csr_wdata;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata;   // value_c0, value_c1, value_c2, value_c3, zero pad
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [TDATA_W-1:0]   rsp_tdata;   // sum_c0, sum_c1, sum_c2, sum_c3, zero pad

   fold_scoreboard sb = new();
   int unsigned    cycle_count = 0;
   int             burst_left = 0;
   int             mix_settings = 1;
   stall_type      stall_mode = READY_ALWAYS;

   extension_fri_fold #(.FOLD(FOLD_DEF)) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Check each sum transaction and stall the response side on a shifting pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_sum(rsp_tdata[ELEM_W-1:0]);
         end
         if (cycle_count % 64 == 0) begin
            stall_mode = stall_type'($urandom_range(0, 3));
         end
         case (stall_mode)
            READY_ALWAYS:   rsp_tready <= 1'b1;
            READY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: rsp_tready <= (cycle_count % 7) < 2;
            default:        rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   function automatic logic [FIELD_W-1:0] random_component();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return PRIME - 31'd1;
               2: return PRIME;
               3: return FIELD_MAX;
               default: return MONT_ONE;
            endcase
         end
         1: return 31'($urandom_range(32'(PRIME), 32'(FIELD_MAX)));
         default: return 31'($urandom_range(0, 32'(PRIME) - 1));
      endcase
   endfunction

   function automatic elem_type random_element();
      elem_type e;
      for (int k = 0; k < 4; k++) begin
         e[k] = random_component();
      end
      return e;
   endfunction

   // Field extremes, unreduced values and bit patterns for the first group
   function automatic elem_type directed_element(int n);
      elem_type e;
      e = '0;
      case (n)
         0: e = '0;
         1: e = {4{PRIME - 31'd1}};
         2: e = {4{PRIME}};
         3: e = {4{FIELD_MAX}};
         4: e[0] = MONT_ONE;
         5: e[3] = MONT_ONE;
         6: e = {4{31'h55555555}};
         7: e = {4{31'h2aaaaaaa}};
         8: e = {31'd0, PRIME - 31'd1, 31'd0, PRIME - 31'd1};
         9: e = {FIELD_MAX, PRIME, 31'd1, 31'd0};
         default: e = random_element();
      endcase
      return e;
   endfunction

   function automatic elem_type mix_setting(int n);
      elem_type m;
      m = '0;
      case (n)
         1: m = '0;
         2: m = {4{PRIME - 31'd1}};
         3: m = {4{FIELD_MAX}};
         4: m[0] = 31'($urandom_range(0, 32'(PRIME) - 1));
         5: for (int k = 0; k < 4; k++) m[k] = 31'($urandom());
         6: m[1] = MONT_ONE;
         default: for (int k = 0; k < 4; k++) m[k] = 31'($urandom_range(0, 32'(PRIME) - 1));
      endcase
      return m;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [FIELD_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.note_mix(idx, value);
   endtask

   task automatic program_mix(input elem_type m);
      write_reg(REG_MIX_C0, m[0]);
      write_reg(REG_MIX_C1, m[1]);
      write_reg(REG_MIX_C2, m[2]);
      write_reg(REG_MIX_C3, m[3]);
      csr_we <= 1'b0;
      @(posedge clock);
      mix_settings++;
   endtask

   // Send one element; open a new burst with a random gap when the current one ends
   task automatic send_element(input elem_type e);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 130);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tdata  <= TDATA_W'(e);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.take_element(e);
      burst_left--;
   endtask

   // Hold off the sender until every sum is back, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= REG_MIX_C0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One full group under the reset mix, then a partial group
      for (int n = 0; n < FOLD_DEF + 8; n++) begin
         send_element(directed_element(n));
      end

      // Change the mix in the middle of groups
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain();
         program_mix(mix_setting(ph));
         repeat (PHASE_ITEMS) send_element(random_element());
      end
      drain();

      $display("Covered %0d elements in %0d folded sums across %0d mix settings",
               sb.elements_taken, sb.sums_checked, mix_settings);
      $display("Run took %0d cycles, %0d mismatches", cycle_count, sb.errors);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
